// ===== src/color_key_run_to_rectangles_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the color key run-to-rectangle unit
// Each macro expands to one labeled concurrent assertion on clock/reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_RUN_TO_RECTANGLES_UNIT_DEFINES_SVH
`define COLOR_KEY_RUN_TO_RECTANGLES_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CKR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CKR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ckr_pkg.sv =====
// ----------------------------------------------------------------------------
// ckr_pkg
// Widths, codes and shared types of the color key run-to-rectangle unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckr_pkg;

   localparam int PIX_W   = 24;
   localparam int OW_W    = 8;
   localparam int COORD_W = 13;
   localparam int RECT_W  = 14;
   localparam int COUNT_W = 11;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM_DEFAULT     = 4096;
   localparam int BATCH_RECTS_DEFAULT = 2000;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTLINE_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd3;

   // result kinds
   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0]   key_color;
      logic [OW_W-1:0]    outline_width;
      logic [COORD_W-1:0] image_width;
      logic [COORD_W-1:0] image_height;
   } ckr_cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } ckr_box_type;

   // everything one pixel produces: an optional rectangle, an optional marker
   typedef struct packed {
      logic              has_rect;
      logic              has_marker;
      logic [RECT_W-1:0] rect_left;
      logic [RECT_W-1:0] rect_top;
      logic [RECT_W-1:0] rect_right;
      logic [RECT_W-1:0] rect_bottom;
      ckr_box_type       rect_box;
      logic              rect_batch_end;
      ckr_box_type       marker_box;
   } ckr_event_type;

endpackage

// ===== src/ckr_scan.sv =====
// ----------------------------------------------------------------------------
// ckr_scan
// Raster position, run tracking and batch bounding box; builds the results
// of one pixel and advances the state when that pixel moves on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckr_scan #(
   parameter int MAX_DIM     = ckr_pkg::MAX_DIM_DEFAULT,
   parameter int BATCH_RECTS = ckr_pkg::BATCH_RECTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [ckr_pkg::PIX_W-1:0]  pixel_word,
   input  ckr_pkg::ckr_cfg_type       cfg,
   output ckr_pkg::ckr_event_type     event_out
);
   import ckr_pkg::*;

   localparam logic [COORD_W-1:0] MaxDimC  = COORD_W'(MAX_DIM);
   localparam logic [COUNT_W-1:0] BatchC   = COUNT_W'(BATCH_RECTS);
   localparam ckr_box_type        BoxClear = '{left: MaxDimC, top: MaxDimC,
                                               right: '0, bottom: '0};

   logic [COORD_W-1:0] column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               run_open_ff, run_open_in;
   logic [COORD_W-1:0] run_start_ff, run_start_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   ckr_box_type        bound_ff, bound_in;

   function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = COORD_W'(1);
      end else if (v > MaxDimC) begin
         r = MaxDimC;
      end
      return r;
   endfunction

   always_comb begin
      logic [COORD_W-1:0] w_last, h_last, start, stop, row_next;
      logic [COUNT_W-1:0] count_inc, count_a;
      logic               opaque, row_end, close_at_key, emit, batch_full, image_end;
      ckr_box_type        box_upd, box_a;

      w_last       = clamp_dim(cfg.image_width) - COORD_W'(1);
      h_last       = clamp_dim(cfg.image_height) - COORD_W'(1);
      opaque       = (pixel_word != cfg.key_color);
      row_end      = (column_ff >= w_last);
      close_at_key = !opaque && run_open_ff;
      emit         = close_at_key || (row_end && (run_open_ff || opaque));
      image_end    = row_end && (row_ff >= h_last);
      start        = run_open_ff ? run_start_ff : column_ff;
      stop         = close_at_key ? column_ff : column_ff + COORD_W'(1);
      row_next     = row_ff + COORD_W'(1);

      box_upd.left   = (start < bound_ff.left) ? start : bound_ff.left;
      box_upd.top    = (row_ff < bound_ff.top) ? row_ff : bound_ff.top;
      box_upd.right  = (stop > bound_ff.right) ? stop : bound_ff.right;
      box_upd.bottom = (row_next > bound_ff.bottom) ? row_next : bound_ff.bottom;

      count_inc  = count_ff + COUNT_W'(1);
      batch_full = (count_inc == BatchC);

      // state after the rectangle, if one is emitted
      box_a   = bound_ff;
      count_a = count_ff;
      if (emit) begin
         box_a   = batch_full ? BoxClear : box_upd;
         count_a = batch_full ? '0 : count_inc;
      end

      event_out.has_rect       = emit;
      event_out.has_marker     = image_end;
      event_out.rect_left      = RECT_W'(start) - RECT_W'(cfg.outline_width);
      event_out.rect_top       = RECT_W'(row_ff) - RECT_W'(cfg.outline_width);
      event_out.rect_right     = RECT_W'(stop) + RECT_W'(cfg.outline_width);
      event_out.rect_bottom    = RECT_W'(row_ff) + RECT_W'(1) + RECT_W'(cfg.outline_width);
      event_out.rect_box       = box_upd;
      event_out.rect_batch_end = batch_full;
      event_out.marker_box     = box_a;

      // next state
      bound_in     = image_end ? BoxClear : box_a;
      count_in     = image_end ? '0 : count_a;
      run_open_in  = emit ? 1'b0 : (run_open_ff || opaque);
      run_start_in = (opaque && !run_open_ff) ? column_ff : run_start_ff;
      column_in    = row_end ? '0 : column_ff + COORD_W'(1);
      row_in       = row_ff;
      if (row_end) begin
         row_in = image_end ? '0 : row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         count_ff     <= '0;
         bound_ff     <= BoxClear;
      end else if (advance) begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
         count_ff     <= count_in;
         bound_ff     <= bound_in;
      end
   end

endmodule

// ===== src/ckr_result.sv =====
// ----------------------------------------------------------------------------
// ckr_result
// Result register: holds the results of one pixel and hands them out in
// order, rectangle first, end-of-image marker second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckr_result (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  ckr_pkg::ckr_event_type            event_in,
   output logic                              slot_free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_left,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_top,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_right,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_bottom,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_left,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_top,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_right,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_bottom,
   output logic                              rsp_batch_end,
   output logic                              rsp_last_result
);
   import ckr_pkg::*;

   logic          has_rect_ff, has_rect_in;
   logic          has_marker_ff, has_marker_in;
   ckr_event_type data_ff;
   logic          take;
   ckr_box_type   box_sel;

   assign rsp_valid       = has_rect_ff || has_marker_ff;
   assign rsp_last_result = has_rect_ff ? !has_marker_ff : 1'b1;
   assign take            = rsp_valid && !rsp_stall;
   assign slot_free       = !rsp_valid || (take && rsp_last_result);

   always_comb begin
      has_rect_in   = has_rect_ff;
      has_marker_in = has_marker_ff;
      if (load) begin
         has_rect_in   = event_in.has_rect;
         has_marker_in = event_in.has_marker;
      end else if (take) begin
         // drop the piece just transferred
         if (has_rect_ff) begin
            has_rect_in = 1'b0;
         end else begin
            has_marker_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_rect_ff   <= 1'b0;
         has_marker_ff <= 1'b0;
      end else begin
         has_rect_ff   <= has_rect_in;
         has_marker_ff <= has_marker_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= event_in;
      end
   end

   assign box_sel         = has_rect_ff ? data_ff.rect_box : data_ff.marker_box;
   assign rsp_kind        = has_rect_ff ? KIND_RECT : KIND_MARKER;
   assign rsp_rect_left   = has_rect_ff ? $signed(data_ff.rect_left) : '0;
   assign rsp_rect_top    = has_rect_ff ? $signed(data_ff.rect_top) : '0;
   assign rsp_rect_right  = has_rect_ff ? $signed(data_ff.rect_right) : '0;
   assign rsp_rect_bottom = has_rect_ff ? $signed(data_ff.rect_bottom) : '0;
   assign rsp_box_left    = box_sel.left;
   assign rsp_box_top     = box_sel.top;
   assign rsp_box_right   = box_sel.right;
   assign rsp_box_bottom  = box_sel.bottom;
   assign rsp_batch_end   = has_rect_ff ? data_ff.rect_batch_end : 1'b1;

endmodule

// ===== src/color_key_run_to_rectangles_unit.sv =====
// ----------------------------------------------------------------------------
// color_key_run_to_rectangles_unit: a pixel passes the input register, then the
// result register. Throughput one pixel per cycle while rsp_stall is low; a pixel
// closing a run at the image end yields two results; the input waits for both.
// Reset is synchronous: position, run, batch and registers return to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "color_key_run_to_rectangles_unit_defines.svh"

module color_key_run_to_rectangles_unit #(
   parameter int MAX_DIM     = ckr_pkg::MAX_DIM_DEFAULT,
   parameter int BATCH_RECTS = ckr_pkg::BATCH_RECTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_wen,
   input  logic [ckr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ckr_pkg::PIX_W-1:0]         csr_wdata,
   // pixel input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ckr_pkg::PIX_W-1:0]         req_pixel_word,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_left,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_top,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_right,
   output logic signed [ckr_pkg::RECT_W-1:0] rsp_rect_bottom,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_left,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_top,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_right,
   output logic [ckr_pkg::COORD_W-1:0]       rsp_box_bottom,
   output logic                              rsp_batch_end,
   output logic                              rsp_last_result
);
   import ckr_pkg::*;

   // Configuration registers. Reset leaves the full 4096 x 4096 frame and a
   // black key color with no outline.
   ckr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_KEY_COLOR:     cfg_in.key_color     = csr_wdata;
            CSR_OUTLINE_WIDTH: cfg_in.outline_width = csr_wdata[OW_W-1:0];
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[COORD_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata[COORD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_color     <= '0;
         cfg_ff.outline_width <= '0;
         cfg_ff.image_width   <= COORD_W'(MAX_DIM_DEFAULT);
         cfg_ff.image_height  <= COORD_W'(MAX_DIM_DEFAULT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register. A pixel sits here while its results are worked out; it
   // moves on (advance) as soon as the result register can take what it
   // produces. The input is stalled only while a pixel is held and cannot
   // move on, so a new pixel may enter in the cycle the held one leaves.
   logic               in_valid_ff, in_valid_in;
   logic [PIX_W-1:0]   pixel_ff;
   logic               slot_free;
   logic               advance;
   logic               req_take;
   ckr_event_type      scan_event;

   assign advance   = in_valid_ff && slot_free;
   assign req_stall = in_valid_ff && !slot_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload until the next transfer replaces it
   always_ff @(posedge clock) begin
      if (req_take) begin
         pixel_ff <= req_pixel_word;
      end
   end

   // Scan state and per-pixel result logic: key compare, run open/close,
   // bounding box update, batch count and end-of-image detection.
   ckr_scan #(
      .MAX_DIM     (MAX_DIM),
      .BATCH_RECTS (BATCH_RECTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pixel_word (pixel_ff),
      .cfg        (cfg_ff),
      .event_out  (scan_event)
   );

   // Result register: up to two results per pixel, rectangle first.
   ckr_result u_result (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .event_in        (scan_event),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_rect_left   (rsp_rect_left),
      .rsp_rect_top    (rsp_rect_top),
      .rsp_rect_right  (rsp_rect_right),
      .rsp_rect_bottom (rsp_rect_bottom),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_right   (rsp_box_right),
      .rsp_box_bottom  (rsp_box_bottom),
      .rsp_batch_end   (rsp_batch_end),
      .rsp_last_result (rsp_last_result)
   );

   // The end-of-image marker always closes the batch and the pixel.
   `CKR_ASSERT_NOW(a_marker_closes, rsp_valid && (rsp_kind == KIND_MARKER), rsp_batch_end && rsp_last_result, "marker without batch end or last flag")

   // A result that is not the last of its pixel is followed by the marker.
   `CKR_ASSERT_NEXT(a_marker_follows, rsp_valid && !rsp_stall && !rsp_last_result, rsp_valid && (rsp_kind == KIND_MARKER), "pending marker lost")

   // A rectangle's batch box always contains a run of at least one pixel.
   `CKR_ASSERT_NOW(a_box_nonempty, rsp_valid && (rsp_kind == KIND_RECT), (rsp_box_right > rsp_box_left) && (rsp_box_bottom > rsp_box_top), "empty batch box on a rectangle")

   // The input stalls only while a pixel is held and the result side is busy.
   `CKR_ASSERT_NOW(a_stall_cause, req_stall, in_valid_ff && rsp_valid, "input stalled without a held pixel")

endmodule
